// ===== hw/rtl/trs_pkg.sv =====
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types, constants and arithmetic helpers for the TRS matrix unit.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NCELL = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } trs_in_t;

  typedef struct packed {
    logic signed [31:0] m_r0c0;
    logic signed [31:0] m_r0c1;
    logic signed [31:0] m_r0c2;
    logic signed [31:0] m_r1c0;
    logic signed [31:0] m_r1c1;
    logic signed [31:0] m_r1c2;
    logic signed [31:0] m_r2c0;
    logic signed [31:0] m_r2c1;
    logic signed [31:0] m_r2c2;
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
  } trs_out_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [35:0] z;
  } trs_cordic_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [2:0]         neg;
  } trs_side_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021687;
      5'd5:    r = 36'sd33543516;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048576;
      5'd11:   r = 36'sd524288;
      5'd12:   r = 36'sd262144;
      5'd13:   r = 36'sd131072;
      5'd14:   r = 36'sd65536;
      5'd15:   r = 36'sd32768;
      5'd16:   r = 36'sd16384;
      5'd17:   r = 36'sd8192;
      5'd18:   r = 36'sd4096;
      5'd19:   r = 36'sd2048;
      5'd20:   r = 36'sd1024;
      5'd21:   r = 36'sd512;
      5'd22:   r = 36'sd256;
      5'd23:   r = 36'sd128;
      default: r = 36'sd0;
    endcase
    return r;
  endfunction

  // Q30 product, rounded half up
  function automatic logic signed [41:0] mul_q30(input logic signed [35:0] a,
                                                 input logic signed [35:0] b);
    logic signed [71:0] p;
    p = 72'(a) * 72'(b) + 72'sd536870912;
    return 42'(p >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/trs_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// trs_cordic_cell
// One CORDIC rotation step for the three angle lanes, registered.
// ----------------------------------------------------------------------------
module trs_cordic_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [4:0]                  idx,
  input  trs_pkg::trs_cordic_t [2:0]  d_in,
  output trs_pkg::trs_cordic_t [2:0]  d_out
);
  import trs_pkg::*;

  trs_cordic_t [2:0] d_r;
  trs_cordic_t [2:0] d_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (d_in[k].z >= 0) begin
        d_nxt[k].x = d_in[k].x - (d_in[k].y >>> idx);
        d_nxt[k].y = d_in[k].y + (d_in[k].x >>> idx);
        d_nxt[k].z = d_in[k].z - atan_q30(idx);
      end else begin
        d_nxt[k].x = d_in[k].x + (d_in[k].y >>> idx);
        d_nxt[k].y = d_in[k].y - (d_in[k].x >>> idx);
        d_nxt[k].z = d_in[k].z + atan_q30(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

// ===== hw/rtl/trs_transform_matrix_unit.sv =====
// A word passes reduction, CORDIC cells, sine/cosine, pair products, rotation, output.
// Throughput: one word per cycle when not stalled, as each CORDIC cell does one step.
// The whole pipeline advances together; it holds while the output word is stalled.
// Reset (rst_n low, synchronous) clears all valid flags; data registers are not reset.
// ----------------------------------------------------------------------------
// trs_transform_matrix_unit
// Model matrix from translation, XYZ Euler angles and scale, Q16.16 out.
// ----------------------------------------------------------------------------
module trs_transform_matrix_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  trs_pkg::trs_in_t  in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output trs_pkg::trs_out_t out_word
);
  import trs_pkg::*;

  localparam int LAST = NCELL + 3;

  logic              adv;
  logic [LAST:0]     vld_r;
  logic [LAST:0]     vld_nxt;
  trs_side_t         side_r [0:LAST];
  trs_cordic_t [2:0] chain [0:NCELL];
  trs_cordic_t [2:0] red_nxt;
  logic [2:0]        neg_nxt;
  logic              out_valid_r;
  trs_out_t          out_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // angle reduction
  always_comb begin
    logic signed [17:0] a [3];
    a[0] = 18'(in_word.angle_x);
    a[1] = 18'(in_word.angle_y);
    a[2] = 18'(in_word.angle_z);
    for (int k = 0; k < 3; k++) begin
      if (a[k] > PI_Q13) begin
        a[k] = a[k] - TWO_PI_Q13;
      end else if (a[k] < -PI_Q13) begin
        a[k] = a[k] + TWO_PI_Q13;
      end
      neg_nxt[k] = 1'b0;
      if (a[k] > HALF_PI_Q13) begin
        a[k] = a[k] - PI_Q13;
        neg_nxt[k] = 1'b1;
      end else if (a[k] < -HALF_PI_Q13) begin
        a[k] = a[k] + PI_Q13;
        neg_nxt[k] = 1'b1;
      end
      red_nxt[k].x = GAIN_Q30;
      red_nxt[k].y = 34'sd0;
      red_nxt[k].z = 36'(a[k]) <<< 17;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain[0]     <= red_nxt;
      side_r[0].tx <= in_word.trans_x;
      side_r[0].ty <= in_word.trans_y;
      side_r[0].tz <= in_word.trans_z;
      side_r[0].sx <= in_word.scale_x;
      side_r[0].sy <= in_word.scale_y;
      side_r[0].sz <= in_word.scale_z;
      side_r[0].neg <= neg_nxt;
      for (int k = 1; k <= LAST; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    trs_cordic_cell u_cell (
      .clk   (clk),
      .en    (adv),
      .idx   (5'(g)),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  // sine / cosine with quadrant fix
  logic signed [35:0] sx_r, cx_r, sy_r, cy_r, sz_r, cz_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= side_r[NCELL].neg[0] ? -36'(chain[NCELL][0].y) : 36'(chain[NCELL][0].y);
      cx_r <= side_r[NCELL].neg[0] ? -36'(chain[NCELL][0].x) : 36'(chain[NCELL][0].x);
      sy_r <= side_r[NCELL].neg[1] ? -36'(chain[NCELL][1].y) : 36'(chain[NCELL][1].y);
      cy_r <= side_r[NCELL].neg[1] ? -36'(chain[NCELL][1].x) : 36'(chain[NCELL][1].x);
      sz_r <= side_r[NCELL].neg[2] ? -36'(chain[NCELL][2].y) : 36'(chain[NCELL][2].y);
      cz_r <= side_r[NCELL].neg[2] ? -36'(chain[NCELL][2].x) : 36'(chain[NCELL][2].x);
    end
  end

  // pair products
  logic signed [35:0] sxsy_r, cxsy_r, cycz_r, cysz_r, cxsz_r, cxcz_r;
  logic signed [35:0] sxcy_r, sxsz_r, sxcz_r, cxcy_r, sy2_r, cz2_r, sz2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sxsy_r <= 36'(mul_q30(sx_r, sy_r));
      cxsy_r <= 36'(mul_q30(cx_r, sy_r));
      cycz_r <= 36'(mul_q30(cy_r, cz_r));
      cysz_r <= 36'(mul_q30(cy_r, sz_r));
      cxsz_r <= 36'(mul_q30(cx_r, sz_r));
      cxcz_r <= 36'(mul_q30(cx_r, cz_r));
      sxcy_r <= 36'(mul_q30(sx_r, cy_r));
      sxsz_r <= 36'(mul_q30(sx_r, sz_r));
      sxcz_r <= 36'(mul_q30(sx_r, cz_r));
      cxcy_r <= 36'(mul_q30(cx_r, cy_r));
      sy2_r  <= sy_r;
      cz2_r  <= cz_r;
      sz2_r  <= sz_r;
    end
  end

  // triple products and rotation entries
  logic signed [35:0] rot_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      rot_r[0] <= cycz_r;
      rot_r[1] <= cysz_r;
      rot_r[2] <= sy2_r;
      rot_r[3] <= 36'(mul_q30(sxsy_r, cz2_r)) - cxsz_r;
      rot_r[4] <= 36'(mul_q30(sxsy_r, sz2_r)) + cxcz_r;
      rot_r[5] <= -sxcy_r;
      rot_r[6] <= -36'(mul_q30(cxsy_r, cz2_r)) - sxsz_r;
      rot_r[7] <= -36'(mul_q30(cxsy_r, sz2_r)) + sxcz_r;
      rot_r[8] <= cxcy_r;
    end
  end

  // scale, saturate, output word
  logic signed [35:0] scl [3];
  always_comb begin
    scl[0] = 36'(side_r[LAST].sx);
    scl[1] = 36'(side_r[LAST].sy);
    scl[2] = 36'(side_r[LAST].sz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.m_r0c0 <= sat32(mul_q30(rot_r[0], scl[0]));
      out_r.m_r0c1 <= sat32(mul_q30(rot_r[1], scl[1]));
      out_r.m_r0c2 <= sat32(mul_q30(rot_r[2], scl[2]));
      out_r.m_r1c0 <= sat32(mul_q30(rot_r[3], scl[0]));
      out_r.m_r1c1 <= sat32(mul_q30(rot_r[4], scl[1]));
      out_r.m_r1c2 <= sat32(mul_q30(rot_r[5], scl[2]));
      out_r.m_r2c0 <= sat32(mul_q30(rot_r[6], scl[0]));
      out_r.m_r2c1 <= sat32(mul_q30(rot_r[7], scl[1]));
      out_r.m_r2c2 <= sat32(mul_q30(rot_r[8], scl[2]));
      out_r.out_tx <= side_r[LAST].tx;
      out_r.out_ty <= side_r[LAST].ty;
      out_r.out_tz <= side_r[LAST].tz;
    end
  end

  always_comb begin
    vld_nxt = {vld_r[LAST-1:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[LAST];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
endmodule

// ===== hw/rtl/trs_check.sv =====
// ----------------------------------------------------------------------------
// trs_check
// Port-level checks for the TRS matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module trs_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input trs_pkg::trs_in_t  in_word,
  input logic              out_valid,
  input logic              out_stall,
  input trs_pkg::trs_out_t out_word
);
  import trs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("output word changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
endmodule

bind trs_transform_matrix_unit trs_check u_trs_check (.*);
